[src/bhtg_pkg.sv]
// ============================================================================
// bhtg_pkg
// Shared types and constants of the breakpoint harmonic tone generator.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package bhtg_pkg;

    // input item modes
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_LOAD    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SAMPLE_RATE = 2'd0;
    localparam logic [1:0] CFG_POINT_COUNT = 2'd1;

    localparam logic [17:0] SAMPLE_RATE_RESET = 18'd48000;
    localparam logic [17:0] MIN_SAMPLE_RATE   = 18'd1000;
    localparam logic [23:0] DEFAULT_FREQ      = 24'd112640;   // 440 Hz in Q16.8
    localparam logic [15:0] DEFAULT_GAIN      = 16'd16384;    // 0.5 in Q1.15
    localparam logic [23:0] COUNTER_MAX       = 24'hFFFFFF;

    typedef struct packed {
        logic [23:0] t;
        logic [23:0] f;
        logic [15:0] g;
    } bp_entry_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD0,
        S_CHK0,
        S_CHKL,
        S_SCAN,
        S_MUL_F,
        S_DST_F,
        S_DIV_F,
        S_MUL_G,
        S_DST_G,
        S_DIV_G,
        S_DST_P,
        S_DIV_P,
        S_SIN_RD,
        S_SIN_MUL,
        S_SIN_ACC,
        S_SCALE,
        S_ROUND
    } state_t;

    // Q15 weights of harmonics one to four
    function automatic logic signed [16:0] harm_weight(input logic [1:0] h);
        logic signed [16:0] w;
        unique case (h)
            2'd0:    w = 17'sd19661;
            2'd1:    w = 17'sd8192;
            2'd2:    w = 17'sd3277;
            default: w = 17'sd1638;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[src/bhtg_if.sv]
// ============================================================================
// bhtg_in_if / bhtg_out_if
// Valid/ready channels carrying input items and result items.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface bhtg_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [2:0]  point_index;
    logic [23:0] point_time;
    logic [23:0] point_freq;
    logic [15:0] point_gain;

    modport source (output valid, mode, point_index, point_time, point_freq, point_gain,
                    input ready);
    modport sink   (input valid, mode, point_index, point_time, point_freq, point_gain,
                    output ready);
endinterface

interface bhtg_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic [23:0]        cur_freq;
    logic [15:0]        cur_gain;

    modport source (output valid, sample, cur_freq, cur_gain, input ready);
    modport sink   (input valid, sample, cur_freq, cur_gain, output ready);
endinterface

`default_nettype wire

[src/bhtg_bp_mem.sv]
// ============================================================================
// bhtg_bp_mem
// Breakpoint store: one write port, one read port with registered data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bhtg_bp_mem
    import bhtg_pkg::*;
#(
    parameter int DEPTH = 8,
    localparam int AW = $clog2(DEPTH)
)(
    input  wire logic      clk,
    input  wire logic      we,
    input  wire logic [AW-1:0] waddr,
    input  wire bp_entry_t wdata,
    input  wire logic [AW-1:0] raddr,
    output bp_entry_t      rdata
);

    bp_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/bhtg_sine_rom.sv]
// ============================================================================
// bhtg_sine_rom
// Full-cycle Q15 sine table built at elaboration, registered read.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bhtg_sine_rom
    import bhtg_pkg::*;
#(
    parameter int ADDR_BITS = 10
)(
    input  wire logic                 clk,
    input  wire logic [ADDR_BITS-1:0] addr,
    output logic signed [15:0]        data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    // quarter-wave Taylor series in Q30, mirrored into four quadrants
    function automatic logic signed [15:0] sine_entry(input int k);
        logic [63:0] quarter;
        logic [63:0] quad;
        logic [63:0] j;
        logic [63:0] m;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        quarter = 64'd1 << (ADDR_BITS - 2);
        quad    = 64'(k) >> (ADDR_BITS - 2);
        j       = 64'(k) & (quarter - 64'd1);
        m       = quad[0] ? quarter - j : j;
        x       = (m * 64'd1686629713) >> (ADDR_BITS - 2);
        x2      = (x * x) >> 30;
        t       = 64'd1 << 30;
        t       = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd110;
        t       = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
        t       = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
        t       = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
        t       = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
        s       = (x * t) >> 30;
        v       = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (quad[1])
        begin
            v = -v;
        end
        return 16'(v);
    endfunction

    logic signed [15:0] lut [DEPTH];

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_lut
        localparam logic signed [15:0] VAL = sine_entry(g);
        assign lut[g] = VAL;
    end

    always_ff @(posedge clk)
    begin
        data <= lut[addr];
    end

endmodule

`default_nettype wire

[src/bhtg_div.sv]
// ============================================================================
// bhtg_div
// Restoring divider, one quotient bit per cycle, 24-bit divisor.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bhtg_div
    import bhtg_pkg::*;
#(
    parameter int DW = 48
)(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [23:0]   divisor,
    output logic [DW-1:0]      quotient,
    output logic               done
);

    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]   quo_reg;
    logic [23:0]     rem_reg;
    logic [23:0]     dvs_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            done_reg;
    logic [24:0]     rem_sh;
    logic            fit;

    assign rem_sh = {rem_reg, quo_reg[DW-1]};
    assign fit    = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNTW'(DW);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - CNTW'(1);
            done_reg <= (cnt_reg == CNTW'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            // shift in next dividend bit, subtract when it fits
            rem_reg <= fit ? 24'(rem_sh - {1'b0, dvs_reg}) : rem_sh[23:0];
            quo_reg <= {quo_reg[DW-2:0], fit};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

[src/breakpoint_harmonic_tone_generator.sv]
// ============================================================================
// breakpoint_harmonic_tone_generator
// Breakpoint envelope driving a four-harmonic sine oscillator.
// ============================================================================
// Usage:
//   din carries items: a load beat writes one breakpoint (time, freq, gain),
//   a restart beat clears the sample time and the phase, a tick beat makes
//   one sample. cfg_we/cfg_index/cfg_data write sample_rate (index 0) and
//   point_count (index 1); write them only while the block is idle.
//   dout carries one beat per tick: sample, cur_freq and cur_gain.
// Sequence:
//   Load and restart finish when they are accepted. A tick walks the breakpoint
//   memory one entry a cycle, runs up to three divides on the shared
//   bit-serial divider (DIV_W = max(48, PHASE_BITS + 16) bits): three for an
//   interpolated sample, one for a held one. Then come four sine reads, each
//   weighted and summed, then gain scaling and rounding. One item is in work
//   at a time.
// Reset:
//   Sample time and phase clear, sample_rate returns to 48000, point_count to
//   0. Breakpoint contents are unknown until loaded.
// Stall:
//   The result sits in the output register; a finished tick waits for it to
//   drain, and din stays low-ready meanwhile. Ticks at sample_rate <= 1000
//   make no beat and change nothing.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module breakpoint_harmonic_tone_generator
    import bhtg_pkg::*;
#(
    parameter int MAX_POINTS     = 8,
    parameter int SINE_ADDR_BITS = 10,
    parameter int PHASE_BITS     = 32
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    bhtg_in_if.sink          din,
    bhtg_out_if.source       dout,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [17:0] cfg_data
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int DIV_W = (PHASE_BITS + 16 > 48) ? PHASE_BITS + 16 : 48;

    // ------------------------------------------------------------------
    // configuration and control state
    // ------------------------------------------------------------------
    state_t                state_reg, state_next;
    logic [17:0]           rate_reg;
    logic [3:0]            count_reg;
    logic [23:0]           time_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [CW-1:0]         idx_reg;
    logic [1:0]            harm_reg;
    logic                  out_valid_reg;

    // payload registers
    bp_entry_t             prev_reg;
    bp_entry_t             cur_reg;
    bp_entry_t             last_reg;
    logic [47:0]           mul_reg;
    logic                  down_reg;
    logic [23:0]           freq_reg;
    logic [15:0]           gain_reg;
    logic signed [31:0]    term_reg;
    logic signed [31:0]    acc_reg;
    logic signed [48:0]    scaled_reg;
    logic signed [15:0]    sample_out_reg;
    logic [23:0]           freq_out_reg;
    logic [15:0]           gain_out_reg;

    // ------------------------------------------------------------------
    // submodule wiring
    // ------------------------------------------------------------------
    logic                      mem_we;
    logic [AW-1:0]             mem_raddr;
    bp_entry_t                 mem_wdata;
    bp_entry_t                 mem_q;
    logic                      div_start;
    logic [DIV_W-1:0]          div_dividend;
    logic [23:0]               div_divisor;
    logic [DIV_W-1:0]          div_q;
    logic                      div_done;
    logic [SINE_ADDR_BITS-1:0] rom_addr;
    logic signed [15:0]        rom_q;

    // ------------------------------------------------------------------
    // derived values
    // ------------------------------------------------------------------
    logic                  accept;
    logic                  tick_go;
    logic [CW-1:0]         n_pts;
    logic [23:0]           seg_num;
    logic [23:0]           seg_den;
    logic [23:0]           diff_f;
    logic [23:0]           diff_g;
    logic [PHASE_BITS-1:0] harm_phase;
    logic                  out_free;
    logic signed [48:0]    round_sum;
    logic signed [18:0]    round_val;
    logic signed [15:0]    sat_val;

    assign accept  = din.valid && din.ready;
    assign tick_go = din.mode == MODE_TICK && rate_reg > MIN_SAMPLE_RATE;
    assign n_pts   = (32'(count_reg) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(count_reg);
    assign seg_num = time_reg - prev_reg.t;
    assign seg_den = cur_reg.t - prev_reg.t;
    assign diff_f  = (cur_reg.f >= prev_reg.f) ? cur_reg.f - prev_reg.f
                                               : prev_reg.f - cur_reg.f;
    assign diff_g  = (cur_reg.g >= prev_reg.g) ? 24'(cur_reg.g - prev_reg.g)
                                               : 24'(prev_reg.g - cur_reg.g);
    assign out_free = !out_valid_reg || dout.ready;

    // rounding to nearest, halves up, then clamp to 16 bits
    assign round_sum = scaled_reg + 49'sd536870912;
    assign round_val = 19'(round_sum >>> 30);
    assign sat_val   = (round_val > 19'sd32767)  ? 16'sd32767  :
                       (round_val < -19'sd32768) ? -16'sd32768 : 16'(round_val);

    always_comb
    begin
        case (harm_reg)
            2'd0:    harm_phase = phase_reg;
            2'd1:    harm_phase = phase_reg << 1;
            2'd2:    harm_phase = phase_reg + (phase_reg << 1);
            default: harm_phase = phase_reg << 2;
        endcase
    end

    assign mem_we = accept && din.mode == MODE_LOAD && 32'(din.point_index) < MAX_POINTS;
    assign mem_wdata = '{t: din.point_time, f: din.point_freq, g: din.point_gain};

    bhtg_bp_mem #(
        .DEPTH (MAX_POINTS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(din.point_index)),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    bhtg_div #(
        .DW (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .done     (div_done)
    );

    bhtg_sine_rom #(
        .ADDR_BITS (SINE_ADDR_BITS)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_q)
    );

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && tick_go)
                begin
                    state_next = (n_pts == '0) ? S_DST_P : S_RD0;
                end
            end
            S_RD0:     state_next = S_CHK0;
            S_CHK0:    state_next = (time_reg <= mem_q.t) ? S_DST_P : S_CHKL;
            S_CHKL:    state_next = (time_reg >= mem_q.t) ? S_DST_P : S_SCAN;
            S_SCAN:
            begin
                if (time_reg >= prev_reg.t && time_reg <= mem_q.t)
                begin
                    state_next = (mem_q.t == prev_reg.t) ? S_DST_P : S_MUL_F;
                end
                else if (idx_reg + CW'(1) >= n_pts)
                begin
                    state_next = S_DST_P;
                end
            end
            S_MUL_F:   state_next = S_DST_F;
            S_DST_F:   state_next = S_DIV_F;
            S_DIV_F:   state_next = div_done ? S_MUL_G : S_DIV_F;
            S_MUL_G:   state_next = S_DST_G;
            S_DST_G:   state_next = S_DIV_G;
            S_DIV_G:   state_next = div_done ? S_DST_P : S_DIV_G;
            S_DST_P:   state_next = S_DIV_P;
            S_DIV_P:   state_next = div_done ? S_SIN_RD : S_DIV_P;
            S_SIN_RD:  state_next = S_SIN_MUL;
            S_SIN_MUL: state_next = S_SIN_ACC;
            S_SIN_ACC: state_next = (harm_reg == 2'd3) ? S_SCALE : S_SIN_RD;
            S_SCALE:   state_next = S_ROUND;
            S_ROUND:   state_next = out_free ? S_IDLE : S_ROUND;
            default:   state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // outputs of the sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        din.ready    = 1'b0;
        mem_raddr    = '0;
        div_start    = 1'b0;
        div_dividend = DIV_W'(mul_reg) + DIV_W'(seg_den >> 1);
        div_divisor  = seg_den;
        rom_addr     = harm_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
        unique case (state_reg)
            S_IDLE:  din.ready = 1'b1;
            S_CHK0:  mem_raddr = AW'(n_pts - CW'(1));
            S_CHKL:  mem_raddr = AW'(1);
            S_SCAN:  mem_raddr = AW'(idx_reg + CW'(1));
            S_DST_F: div_start = 1'b1;
            S_DST_G: div_start = 1'b1;
            S_DST_P:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(freq_reg) << (PHASE_BITS - 8);
                div_divisor  = 24'(rate_reg);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rate_reg      <= SAMPLE_RATE_RESET;
            count_reg     <= '0;
            time_reg      <= '0;
            phase_reg     <= '0;
            idx_reg       <= '0;
            harm_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SAMPLE_RATE: rate_reg  <= cfg_data;
                    CFG_POINT_COUNT: count_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end

            if (accept && din.mode == MODE_RESTART)
            begin
                time_reg  <= '0;
                phase_reg <= '0;
            end

            // scan starts at the second entry
            if (state_reg == S_CHKL)
            begin
                idx_reg <= CW'(1);
            end
            else if (state_reg == S_SCAN)
            begin
                idx_reg <= idx_reg + CW'(1);
            end

            if (state_reg == S_DIV_P && div_done)
            begin
                phase_reg <= phase_reg + div_q[PHASE_BITS-1:0];
                harm_reg  <= '0;
            end
            else if (state_reg == S_SIN_ACC)
            begin
                harm_reg <= harm_reg + 2'd1;
            end

            if (state_reg == S_ROUND && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (time_reg < COUNTER_MAX)
                begin
                    time_reg <= time_reg + 24'd1;
                end
            end
            else if (dout.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                freq_reg <= DEFAULT_FREQ;
                gain_reg <= DEFAULT_GAIN;
            end
            S_CHK0:
            begin
                prev_reg <= mem_q;
                freq_reg <= mem_q.f;
                gain_reg <= mem_q.g;
            end
            S_CHKL:
            begin
                last_reg <= mem_q;
                freq_reg <= mem_q.f;
                gain_reg <= mem_q.g;
            end
            S_SCAN:
            begin
                cur_reg <= mem_q;
                if (time_reg >= prev_reg.t && time_reg <= mem_q.t)
                begin
                    // found segment starts from its start values; a zero-length one keeps them
                    freq_reg <= prev_reg.f;
                    gain_reg <= prev_reg.g;
                end
                else
                begin
                    prev_reg <= mem_q;
                    freq_reg <= last_reg.f;
                    gain_reg <= last_reg.g;
                end
            end
            S_MUL_F:
            begin
                mul_reg  <= diff_f * seg_num;
                down_reg <= cur_reg.f < prev_reg.f;
            end
            S_DIV_F:
            begin
                if (div_done)
                begin
                    freq_reg <= down_reg ? prev_reg.f - div_q[23:0] : prev_reg.f + div_q[23:0];
                end
            end
            S_MUL_G:
            begin
                mul_reg  <= diff_g * seg_num;
                down_reg <= cur_reg.g < prev_reg.g;
            end
            S_DIV_G:
            begin
                if (div_done)
                begin
                    gain_reg <= down_reg ? prev_reg.g - div_q[15:0] : prev_reg.g + div_q[15:0];
                end
            end
            S_DIV_P:   acc_reg  <= '0;
            S_SIN_MUL: term_reg <= harm_weight(harm_reg) * rom_q;
            S_SIN_ACC: acc_reg  <= acc_reg + term_reg;
            S_SCALE:   scaled_reg <= acc_reg * $signed({1'b0, gain_reg});
            S_ROUND:
            begin
                if (out_free)
                begin
                    sample_out_reg <= sat_val;
                    freq_out_reg   <= freq_reg;
                    gain_out_reg   <= gain_reg;
                end
            end
            default: ;
        endcase
    end

    assign dout.valid    = out_valid_reg;
    assign dout.sample   = sample_out_reg;
    assign dout.cur_freq = freq_out_reg;
    assign dout.cur_gain = gain_out_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_low_rate_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && din.mode == MODE_TICK && rate_reg <= MIN_SAMPLE_RATE)
        |=> state_reg == S_IDLE)
        else $error("tick at low sample rate left idle");

    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !(accept && din.mode == MODE_RESTART))
        |=> $stable(phase_reg))
        else $error("phase moved outside a tick");

    a_out_from_round: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_ROUND)
        else $error("result beat raised outside rounding step");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_F || state_reg == S_DIV_G
                      || state_reg == S_DIV_P))
        else $error("divider finished while not awaited");

endmodule

`default_nettype wire
